// ----- rtl/tccw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants for the text console cell writer
// Screen geometry, operation and control character codes, transaction
// payload types and the cell address helper.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  // Transaction field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Internal cursor widths; the column temp holds up to COLS + 3 (tab)
  localparam int CROW_W = $clog2(ROWS);
  localparam int CCOL_W = $clog2(COLS);
  localparam int CTMP_W = $clog2(COLS + 4);

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Control characters and defaults
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd31;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] color;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_color;
  } out_item_t;

  // Cell store port request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Linear cell address: row * COLS + col
  function automatic logic [ADDR_W-1:0] cell_addr(logic [CROW_W-1:0] r,
                                                  logic [CCOL_W-1:0] c);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(r) * ADDR_W'(COLS);
    return base + ADDR_W'(c);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tccw_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_if: valid/ready channels of the text console cell writer
// One interface for the command channel, one for the response channel.
// ----------------------------------------------------------------------------
interface tccw_in_if;
  logic               valid;
  logic               ready;
  tccw_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccw_out_if;
  logic                valid;
  logic                ready;
  tccw_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/text_console_cell_writer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit: 80x25 text console cell store and cursor
// Sequencer around a cell memory with one write port and one read port; every command returns one
// response carrying the cursor and, for reads, the addressed cell.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : command channel (op, char_code, color, row, col), valid/ready.
//   out_o : response channel (cursor_row, cursor_col, read_char, read_color).
//   A transaction completes at a rising edge with valid and ready high.
// Response timing and throughput:
//   Put character without scroll and set cursor: registered response, valid in
//   the cycle after the command; a new command every cycle while the response is taken.
//   Read cell: registered memory read into S_READ, then the response register.
//   Clear screen: fill sweep of ROWS*COLS = 2000 cells, one cell per cycle.
//   Scroll (put past the last row): copy of 1920 cells plus blanking of 80,
//   one memory write per cycle.
// Reset:
//   After rst_ni the memory is filled with spaces in attribute 31, one cell a
//   cycle over all 2000 cells; in_i.ready stays low until that pass ends.
// Stall:
//   The response sits in an output register until out_o.ready; a new command
//   is taken in the cycle the register drains or while it is empty.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit (
  input  wire     clk_i,
  input  wire     rst_ni,
  tccw_in_if.sink    in_i,
  tccw_out_if.source out_o
);
  import tccw_pkg::*;

  typedef enum logic [4:0] {
    S_FILL   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_BLANK  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] wa_q, wa_d;
  logic              pend_q, pend_d;
  logic              reply_q, reply_d;
  logic [CROW_W-1:0] row_q, row_d;
  logic [CCOL_W-1:0] col_q, col_d;
  logic [ATTR_W-1:0] attr_q, attr_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  ram_req_t          ram_req;
  logic [CELL_W-1:0] rd_data;

  logic              accept;
  in_item_t          cmd;
  logic [CROW_W-1:0] sat_row;
  logic [CCOL_W-1:0] sat_col;
  logic [CTMP_W-1:0] col_inc;
  logic [CTMP_W-1:0] tab_col;
  logic              wrap;
  logic [CCOL_W-1:0] wcol;
  logic              load_out;
  logic [CHAR_W-1:0] rsp_char;
  logic [ATTR_W-1:0] rsp_color;

  tccw_cell_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  assign cmd         = in_i.data;
  assign in_i.ready  = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // address saturation and column arithmetic
  always_comb begin
    sat_row = (cmd.row > ROW_W'(ROWS - 1)) ? CROW_W'(ROWS - 1) : CROW_W'(cmd.row);
    sat_col = (cmd.col > COL_W'(COLS - 1)) ? CCOL_W'(COLS - 1) : CCOL_W'(cmd.col);
    col_inc = CTMP_W'(col_q) + CTMP_W'(1);
    tab_col = (CTMP_W'(col_q) + CTMP_W'(4)) & ~CTMP_W'(3);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    wa_d      = wa_q;
    pend_d    = 1'b0;
    reply_d   = reply_q;
    row_d     = row_q;
    col_d     = col_q;
    attr_d    = attr_q;
    wrap      = 1'b0;
    wcol      = col_q;
    load_out  = 1'b0;
    rsp_char  = '0;
    rsp_color = '0;
    ram_req   = '0;

    unique case (state_q)
      // blank sweep after reset and for clear screen
      S_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q;
        ram_req.wdata = {attr_q, CH_SPACE};
        idx_d         = idx_q + ADDR_W'(1);
        if (idx_q == ADDR_W'(CELLS - 1)) begin
          state_d  = S_IDLE;
          load_out = reply_q;
          reply_d  = 1'b0;
        end
      end

      S_IDLE: begin
        if (accept) begin
          unique case (cmd.op)
            OP_PUT: begin
              priority if (cmd.char_code == CH_NL) begin
                wrap = 1'b1;
              end else if (cmd.char_code == CH_CR) begin
                col_d = '0;
              end else if (cmd.char_code == CH_BS) begin
                if (col_q != '0) begin
                  wcol          = col_q - CCOL_W'(1);
                  col_d         = wcol;
                  ram_req.we    = 1'b1;
                  ram_req.waddr = cell_addr(row_q, wcol);
                  ram_req.wdata = {cmd.color, CH_SPACE};
                end
              end else if (cmd.char_code == CH_TAB) begin
                if (tab_col >= CTMP_W'(COLS)) begin
                  wrap = 1'b1;
                end else begin
                  col_d = CCOL_W'(tab_col);
                end
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cell_addr(row_q, col_q);
                ram_req.wdata = {cmd.color, cmd.char_code};
                if (col_inc >= CTMP_W'(COLS)) begin
                  wrap = 1'b1;
                end else begin
                  col_d = CCOL_W'(col_inc);
                end
              end
              // line advance, scrolling from the last row
              if (wrap) begin
                col_d = '0;
                if (row_q == CROW_W'(ROWS - 1)) begin
                  state_d = S_SCROLL;
                  idx_d   = '0;
                end else begin
                  row_d = row_q + CROW_W'(1);
                end
              end
              load_out = !(wrap && (row_q == CROW_W'(ROWS - 1)));
            end
            OP_CLEAR: begin
              attr_d  = cmd.color;
              row_d   = '0;
              col_d   = '0;
              idx_d   = '0;
              reply_d = 1'b1;
              state_d = S_FILL;
            end
            OP_SET: begin
              row_d    = sat_row;
              col_d    = sat_col;
              load_out = 1'b1;
            end
            OP_READ: begin
              ram_req.raddr = cell_addr(sat_row, sat_col);
              state_d       = S_READ;
            end
            default: ;
          endcase
        end
      end

      // read data arrives in the cycle after the address
      S_READ: begin
        rsp_char  = rd_data[CHAR_W-1:0];
        rsp_color = rd_data[CELL_W-1:CHAR_W];
        load_out  = 1'b1;
        state_d   = S_IDLE;
      end

      // copy row r+1 into row r, read one cell ahead of the write
      S_SCROLL: begin
        if (pend_q) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = wa_q;
          ram_req.wdata = rd_data;
        end
        if (idx_q != ADDR_W'(CELLS - COLS)) begin
          ram_req.raddr = idx_q + ADDR_W'(COLS);
          wa_d          = idx_q;
          pend_d        = 1'b1;
          idx_d         = idx_q + ADDR_W'(1);
        end else begin
          state_d = S_BLANK;
        end
      end

      // blank the bottom row in the default attribute
      S_BLANK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q;
        ram_req.wdata = {attr_q, CH_SPACE};
        idx_d         = idx_q + ADDR_W'(1);
        if (idx_q == ADDR_W'(CELLS - 1)) begin
          state_d  = S_IDLE;
          load_out = 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // response register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d      = 1'b1;
      out_d.cursor_row = ROW_W'(row_d);
      out_d.cursor_col = COL_W'(col_d);
      out_d.read_char  = rsp_char;
      out_d.read_color = rsp_color;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      reply_q     <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      attr_q      <= RESET_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      reply_q     <= reply_d;
      row_q       <= row_d;
      col_q       <= col_d;
      attr_q      <= attr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wa_q  <= wa_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire

// ----- rtl/tccw_cell_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_cell_ram: screen cell store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_ram (
  input  wire                          clk_i,
  input  wire tccw_pkg::ram_req_t      req_i,
  output logic [tccw_pkg::CELL_W-1:0]  rd_data_o
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[req_i.raddr];
  end

endmodule
`default_nettype wire

// ----- tb/tb_text_console_cell_writer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer_unit: self-checking bench for the console writer
// Drives commands over the valid/ready command channel and predicts every
// response with a shadow screen, cursor and default attribute kept in the
// bench. Directed cases cover control characters, wrap, scroll, clear and
// address saturation. They are followed by random text runs, read-backs,
// cursor moves and noise, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer_unit;
  import tccw_pkg::*;

  localparam int RANDOM_ITEMS = 730;
  localparam int SINK_HOLD    = 400;
  localparam int IDLE_LIMIT   = 10000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TAB_STOP     = 4;

  logic clk_i;
  logic rst_ni;

  tccw_in_if  in_if ();
  tccw_out_if out_if ();

  text_console_cell_writer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow console state
  logic [CELL_W-1:0] shadow_screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] def_attr;

  out_item_t pending_responses [$];
  int        err_count;
  bit        tight_stream;
  bit        sink_hold_req;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic fill_screen(input logic [ATTR_W-1:0] attr);
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {attr, CH_SPACE};
  endtask

  // Step to the next line; past the last row everything moves up one row
  task automatic advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i + COLS < CELLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {def_attr, CH_SPACE};
      cur_row = ROWS - 1;
    end
  endtask

  task automatic console_apply(input in_item_t cmd, output out_item_t resp);
    int                r;
    int                c;
    logic [CELL_W-1:0] scr_word;
    r = (cmd.row > ROWS - 1) ? ROWS - 1 : int'(cmd.row);
    c = (cmd.col > COLS - 1) ? COLS - 1 : int'(cmd.col);
    resp = '0;
    case (cmd.op)
      OP_PUT: begin
        if (cmd.char_code == CH_NL) begin
          advance_line();
        end else if (cmd.char_code == CH_CR) begin
          cur_col = 0;
        end else if (cmd.char_code == CH_BS) begin
          // backspace at column zero does nothing
          if (cur_col > 0) begin
            cur_col--;
            shadow_screen[cur_row * COLS + cur_col] = {cmd.color, CH_SPACE};
          end
        end else if (cmd.char_code == CH_TAB) begin
          cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
          if (cur_col >= COLS) advance_line();
        end else begin
          shadow_screen[cur_row * COLS + cur_col] = {cmd.color, cmd.char_code};
          cur_col++;
          if (cur_col >= COLS) advance_line();
        end
      end
      OP_CLEAR: begin
        def_attr = cmd.color;
        fill_screen(cmd.color);
        cur_row = 0;
        cur_col = 0;
      end
      OP_SET: begin
        cur_row = r;
        cur_col = c;
      end
      default: begin
        scr_word = shadow_screen[r * COLS + c];
        resp.read_char  = scr_word[CHAR_W-1:0];
        resp.read_color = scr_word[CELL_W-1:CHAR_W];
      end
    endcase
    resp.cursor_row = ROW_W'(cur_row);
    resp.cursor_col = COL_W'(cur_col);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Idle length: mostly none or short, a few long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_cmd(op_e op, logic [CHAR_W-1:0] ch,
                                        logic [ATTR_W-1:0] color,
                                        logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    in_item_t cmd;
    cmd.op        = op;
    cmd.char_code = ch;
    cmd.color     = color;
    cmd.row       = row;
    cmd.col       = col;
    return cmd;
  endfunction

  // Every field random, the op too
  function automatic in_item_t rand_cmd();
    logic [31:0] raw;
    in_item_t    cmd;
    raw = $urandom;
    cmd = raw[$bits(in_item_t)-1:0];
    return cmd;
  endfunction

  function automatic in_item_t rand_put();
    in_item_t cmd;
    int       p;
    cmd    = rand_cmd();
    cmd.op = OP_PUT;
    p      = $urandom_range(0, 99);
    if (p >= 94)      cmd.char_code = CH_TAB;
    else if (p >= 88) cmd.char_code = CH_BS;
    else if (p >= 84) cmd.char_code = CH_CR;
    else if (p >= 80) cmd.char_code = CH_NL;
    return cmd;
  endfunction

  // One command transaction; the response is predicted at acceptance
  task automatic send_cmd(input in_item_t cmd);
    int        gap;
    out_item_t resp;
    gap = tight_stream ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= cmd;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    console_apply(cmd, resp);
    pending_responses.push_back(resp);
  endtask

  // Sender pauses until every response is back
  task automatic wait_all_responses();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_printable_extremes();
    send_cmd(make_cmd(OP_PUT, 8'h00, 8'hFF, '0, '0));
    send_cmd(make_cmd(OP_PUT, 8'hFF, 8'h00, '0, '0));
    send_cmd(make_cmd(OP_PUT, 8'h41, 8'h5A, '0, '0));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd0, 7'd1));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd0, 7'd2));
  endtask

  task automatic test_control_chars();
    send_cmd(make_cmd(OP_PUT, CH_CR, 8'h00, '0, '0));
    send_cmd(make_cmd(OP_PUT, CH_BS, 8'h77, '0, '0));   // at column zero
    send_cmd(make_cmd(OP_PUT, 8'h62, 8'h11, '0, '0));
    send_cmd(make_cmd(OP_PUT, CH_BS, 8'hC3, '0, '0));   // erase previous cell
    send_cmd(make_cmd(OP_PUT, CH_TAB, 8'h00, '0, '0));
    send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 5'd3, 7'd78));
    send_cmd(make_cmd(OP_PUT, CH_TAB, 8'h00, '0, '0));  // tab past the edge
    send_cmd(make_cmd(OP_PUT, CH_NL, 8'h00, '0, '0));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd0, 7'd0));
  endtask

  task automatic test_wrap_and_scroll();
    send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 5'd24, 7'd79));
    send_cmd(make_cmd(OP_PUT, 8'h5A, 8'hE4, '0, '0));   // wrap on the last row
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd23, 7'd79));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd24, 7'd0));
    send_cmd(make_cmd(OP_PUT, CH_NL, 8'h00, '0, '0));   // newline on the last row
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd22, 7'd79));
  endtask

  task automatic test_clear_screen();
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 8'h00, '0, '0));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd12, 7'd40));
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 8'hFF, '0, '0));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd24, 7'd79));
  endtask

  task automatic test_address_saturation();
    send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 5'd31, 7'd127));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 5'd31, 7'd127));
  endtask

  // Response side held off while commands keep coming, then a full drain
  task automatic test_backpressure();
    in_item_t cmd;
    send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 5'd0, 7'd0));
    wait_all_responses();
    sink_hold_req = 1'b1;
    tight_stream  = 1'b1;
    repeat (30) begin
      cmd           = rand_cmd();
      cmd.op        = OP_PUT;
      cmd.char_code = 8'h30 + 8'($urandom_range(0, 40));
      send_cmd(cmd);
    end
    tight_stream = 1'b0;
    wait_all_responses();
  endtask

  task automatic test_random_traffic();
    int       sent;
    int       kind;
    int       len;
    in_item_t cmd;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tight_stream = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // text run
        len = $urandom_range(3, 20);
        repeat (len) send_cmd(rand_put());
        sent += len;
      end else if (kind < 65) begin
        // read back near the cursor
        len = $urandom_range(1, 6);
        repeat (len) begin
          cmd     = rand_cmd();
          cmd.op  = OP_READ;
          cmd.row = ROW_W'((cur_row > 0 && $urandom_range(0, 1)) ? cur_row - 1 : cur_row);
          if ($urandom_range(0, 7) != 0) cmd.col = COL_W'($urandom_range(0, COLS - 1));
          send_cmd(cmd);
        end
        sent += len;
      end else if (kind < 85) begin
        cmd    = rand_cmd();
        cmd.op = OP_SET;
        send_cmd(cmd);
        sent++;
      end else if (kind < 87) begin
        cmd    = rand_cmd();
        cmd.op = OP_CLEAR;
        send_cmd(cmd);
        sent++;
      end else if (kind < 97) begin
        // noise
        send_cmd(rand_cmd());
        sent++;
      end else begin
        wait_all_responses();
      end
    end
    tight_stream = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    rst_ni        = 1'b0;
    err_count     = 0;
    tight_stream  = 1'b0;
    sink_hold_req = 1'b0;
    def_attr      = RESET_ATTR;
    cur_row       = 0;
    cur_col       = 0;
    fill_screen(RESET_ATTR);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_printable_extremes();
    test_control_chars();
    test_wrap_and_scroll();
    test_clear_screen();
    test_address_saturation();
    test_backpressure();
    test_random_traffic();

    wait_all_responses();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived", $realtime, pending_responses.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Response ready: random runs and stalls, plus the requested long hold
  initial begin : sink_proc
    int   hold_left;
    int   run_left;
    int   stall_left;
    logic rdy;
    hold_left    = 0;
    run_left     = 0;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = SINK_HOLD - 1;
        rdy           = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 20);
        stall_left = idle_len();
        rdy        = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  // Response check against the oldest prediction
  always @(posedge clk_i) begin : resp_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = out_if.data;
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response row=%0d col=%0d char=%02h color=%02h",
                 $realtime, got.cursor_row, got.cursor_col, got.read_char, got.read_color);
        err_count++;
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) begin
          $display({"%0t: mismatch expected row=%0d col=%0d char=%02h color=%02h,",
                    " actual row=%0d col=%0d char=%02h color=%02h"},
                   $realtime, want.cursor_row, want.cursor_col, want.read_char,
                   want.read_color, got.cursor_row, got.cursor_col, got.read_char,
                   got.read_color);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
